/* hw/rtl/lpd_pkg.sv */
`default_nettype none

package lpd_pkg;

  localparam int DATA_W      = 8;   // stream byte
  localparam int LEN_W       = 7;   // message_length field
  localparam int STAT_W      = 2;   // status field
  localparam int CNT_W       = 7;   // bytes held counter
  localparam int KEY_W       = 32;  // length word and key
  localparam int LEN_BYTES   = 4;   // bytes of the length word
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_FIELD_W = DATA_W + LEN_W;  // out_byte and message_length
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input byte
    logic latch_len;  // capture decoded length and error kind
    logic rd_first;   // read store entry zero
    logic rd_next;    // read the following store entry
    logic load_msg;   // load a message byte into the output register
    logic load_err;   // load an error result into the output register
    logic clear;      // drop the current frame
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr_full;   // this byte completes the header
    logic msg_full;   // this byte completes the message
    logic dec_short;
    logic dec_long;
    logic dec_emit;   // header alone is the whole message
    logic out_free;   // output register can take a result this cycle
    logic snd_last;   // byte being read is the last of the message
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lpd_ram.sv */
`default_nettype none

module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpd_ctrl.sv */
`default_nettype none

module lpd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire lpd_pkg::stat_t stat,
  output lpd_pkg::cmd_t       cmd
);

  import lpd_pkg::*;

  typedef enum logic [5:0] {
    S_HDR    = 6'b000001,
    S_DECODE = 6'b000010,
    S_BODY   = 6'b000100,
    S_ERR    = 6'b001000,
    S_RD     = 6'b010000,
    S_SEND   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == S_HDR) || (state_r == S_BODY);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HDR: begin
        cmd.accept = in_fire;
        if (in_fire && stat.hdr_full) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.latch_len = 1'b1;
        if (stat.dec_short || stat.dec_long) begin
          state_nxt = S_ERR;
        end else if (stat.dec_emit) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        cmd.accept = in_fire;
        if (in_fire && stat.msg_full) begin
          state_nxt = S_RD;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.load_err = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_HDR;
        end
      end
      S_RD: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_SEND;
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.load_msg = 1'b1;
          if (stat.snd_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_HDR;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpd_dpath.sv */
`default_nettype none

module lpd_dpath #(
  parameter int HEADER_BYTES = 4,
  parameter int MAX_MESSAGE  = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpd_pkg::KEY_W-1:0]       cfg_wdata,
  input  wire logic [lpd_pkg::DATA_W-1:0]      in_byte,
  input  wire lpd_pkg::cmd_t                   cmd,
  output lpd_pkg::stat_t                       stat,
  input  wire logic                            out_tready,
  output logic                                 out_valid_r,
  output logic      [lpd_pkg::DATA_W-1:0]      out_byte_r,
  output lpd_pkg::status_t                     out_status_r,
  output logic      [lpd_pkg::LEN_W-1:0]       out_len_r,
  output logic                                 out_last_r
);

  import lpd_pkg::*;

  localparam int AW  = $clog2(MAX_MESSAGE);
  localparam int HIW = $clog2(LEN_BYTES);

  logic [KEY_W-1:0]  key_r;
  logic              big_r;
  logic [CNT_W-1:0]  held_r, held_inc;
  logic [DATA_W-1:0] hdr_r [LEN_BYTES];
  logic [LEN_W-1:0]  exp_len_r;
  logic              err_long_r;
  logic [AW-1:0]     snd_idx_r, rd_addr;
  logic [KEY_W-1:0]  len_word, len_dec;
  logic [DATA_W-1:0] rd_data;
  logic              out_valid_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      big_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LENGTH_KEY) begin
        key_r <= cfg_wdata;
      end else if (cfg_index == CFG_BIG_ENDIAN) begin
        big_r <= cfg_wdata[0];
      end
    end
  end

  assign held_inc = held_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.clear) begin
      held_r <= '0;
    end else if (cmd.accept) begin
      held_r <= held_inc;
    end
  end

  // first bytes kept aside for the length word
  always_ff @(posedge clk) begin
    if (cmd.accept && (held_r < CNT_W'(LEN_BYTES))) begin
      hdr_r[held_r[HIW-1:0]] <= in_byte;
    end
  end

  assign len_word = big_r ? {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3]}
                          : {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign len_dec  = len_word ^ key_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      exp_len_r  <= len_dec[LEN_W-1:0];
      err_long_r <= stat.dec_long;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      snd_idx_r <= '0;
    end else if (cmd.rd_next) begin
      snd_idx_r <= snd_idx_r + AW'(1);
    end
  end

  assign rd_addr = cmd.rd_first ? '0 : (snd_idx_r + AW'(1));

  lpd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_MESSAGE)
  ) u_store (
    .clk     (clk),
    .we      (cmd.accept && (held_r < CNT_W'(MAX_MESSAGE))),
    .waddr   (held_r[AW-1:0]),
    .wdata   (in_byte),
    .re      (cmd.rd_first || cmd.rd_next),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  always_comb begin
    stat           = '0;
    stat.hdr_full  = (held_inc == CNT_W'(HEADER_BYTES));
    stat.msg_full  = (held_inc >= exp_len_r);
    stat.dec_short = (len_dec < KEY_W'(HEADER_BYTES));
    stat.dec_long  = (len_dec > KEY_W'(MAX_MESSAGE));
    stat.dec_emit  = (held_r >= len_dec[LEN_W-1:0]);
    stat.out_free  = !out_valid_r || out_tready;
    stat.snd_last  = ((LEN_W'(snd_idx_r) + LEN_W'(1)) == exp_len_r);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_msg || cmd.load_err) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_msg) begin
      out_byte_r   <= rd_data;
      out_status_r <= ST_OK;
      out_len_r    <= exp_len_r;
      out_last_r   <= stat.snd_last;
    end else if (cmd.load_err) begin
      out_byte_r   <= '0;
      out_status_r <= err_long_r ? ST_LONG : ST_SHORT;
      out_len_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/length_prefixed_deframer.sv */
// length-prefixed message deframer
// in_* : one received stream byte per beat (in_tdata[7:0])
// out_*: one beat per message byte, header included, kind in tuser, tlast on last byte;
//        a bad length gives a single error beat with zero byte and length, tlast high
// cfg_*: write-only registers, index 0 length key (xored with the length word),
//        index 1 length byte order (0 little endian, 1 big endian); write only
//        while no frame is in flight
// header bytes are taken one per cycle; the cycle after the last header byte
// decodes the length (first four header bytes) and checks it against the
// header size and the store size
// body bytes are taken one per cycle into a single-port-write store of
// MAX_MESSAGE bytes; input stalls in the decode cycle and from the frame's last byte
// until its results are all loaded into the output register
// playback of an n-byte message reads entry zero in the read state, then gives n
// beats at one per cycle while the receiver keeps up, via the registered read port
// frame steps: header bytes, decode cycle, body bytes, read state, output beats;
// a bad length gives its error beat after decode; a message's first beat is loaded
// after the read state, which follows its last byte or a header-only frame's decode
// receiver stall: the output register holds its beat and playback pauses
// reset: state, count and tvalid cleared, key 0, little endian, no frame in progress
`default_nettype none

module length_prefixed_deframer #(
  parameter int HEADER_BYTES = 4,
  parameter int MAX_MESSAGE  = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lpd_pkg::KEY_W-1:0]           cfg_wdata,
  // byte stream in
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lpd_pkg::DATA_W-1:0]          in_tdata,   // data_byte
  // message stream out
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [lpd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // out_byte, message_length
  output logic      [lpd_pkg::STAT_W-1:0]          out_tuser,  // status
  output logic                                     out_tlast
);

  import lpd_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [DATA_W-1:0] out_byte;
  status_t           out_status;
  logic [LEN_W-1:0]  out_len;

  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpd_dpath #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_MESSAGE  (MAX_MESSAGE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_valid_r  (out_tvalid),
    .out_byte_r   (out_byte),
    .out_status_r (out_status),
    .out_len_r    (out_len),
    .out_last_r   (out_tlast)
  );

  // pack fields from the lowest bit up, pad to whole bytes
  assign out_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_len, out_byte};
  assign out_tuser = out_status;

  // an error beat always closes its frame
  a_err_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_status != ST_OK)) |-> out_tlast)
    else $error("error beat without tlast");

  // a message beat carries a length the checks allowed
  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_status == ST_OK)) |->
      ((out_len >= LEN_W'(HEADER_BYTES)) && (out_len <= LEN_W'(MAX_MESSAGE))))
    else $error("message beat with out-of-range length");

  // taking input, latching the length and loading a result never happen together
  a_cmd_excl : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.latch_len, cmd.load_msg, cmd.load_err}))
    else $error("conflicting datapath commands");

  // input is not taken while a result is being loaded for output
  a_no_in_while_out : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_msg || cmd.load_err) |-> !in_tready)
    else $error("input ready during playback");

endmodule

`default_nettype wire
